/* design/mdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdc_pkg
// Shared types, register indexes and CORDIC constants for the converter.
// ----------------------------------------------------------------------------
package mdc_pkg;

  localparam int WORD_BITS = 34;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int GUARD_BITS = 16;
  localparam int ANGLE_BITS = 34;
  localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;

  localparam logic [CFG_IDX_BITS-1:0] REG_FORMAT = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IN_COLS = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COL_OFS = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_COL_STEP = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUT_COLS = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_OFS = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_STEP = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUT_ROWS = 3'd7;

  localparam logic [1:0] FMT_COMPLEX = 2'd0;
  localparam logic [1:0] FMT_POWER = 2'd1;

  typedef struct packed {
    logic [1:0] fmt;
    logic       last_row;
    logic       last_frame;
  } tag_t;

  function automatic logic signed [ANGLE_BITS-1:0] atan_entry(input int i);
    logic signed [ANGLE_BITS-1:0] t;
    case (i)
      0: t = 34'sd536870912;   1: t = 34'sd316933406;
      2: t = 34'sd167458907;   3: t = 34'sd85004756;
      4: t = 34'sd42667331;    5: t = 34'sd21354465;
      6: t = 34'sd10679838;    7: t = 34'sd5340245;
      8: t = 34'sd2670163;     9: t = 34'sd1335087;
      10: t = 34'sd667544;     11: t = 34'sd333772;
      12: t = 34'sd166886;     13: t = 34'sd83443;
      14: t = 34'sd41722;      15: t = 34'sd20861;
      16: t = 34'sd10430;      17: t = 34'sd5215;
      18: t = 34'sd2608;       19: t = 34'sd1304;
      20: t = 34'sd652;        21: t = 34'sd326;
      22: t = 34'sd163;        23: t = 34'sd81;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

/* design/mdc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdc_front
// Holds registers and grid counters; classifies each pixel as kept or dropped.
// ----------------------------------------------------------------------------
module mdc_front import mdc_pkg::*; #(
  parameter int MAX_COLUMNS = 16384
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_fire,
  output logic                     keep,
  output tag_t                     tag
);

  logic [1:0]  fmt;
  logic [14:0] in_cols, out_cols;
  logic [13:0] col_ofs;
  logic [7:0]  col_step, row_step;
  logic [15:0] row_ofs, out_rows;

  logic [16:0] in_col, next_col;
  logic [24:0] in_row, next_row;
  logic [15:0] out_col_cnt;
  logic [16:0] out_row_cnt;

  logic [16:0] rowlen, cols, rows;
  logic [7:0]  cstep, rstep;
  logic        done, kept_row, row_end;

  always_comb begin
    rowlen = (in_cols == '0) ? 17'd1 : {2'b0, in_cols};
    if (rowlen > 17'(MAX_COLUMNS)) rowlen = 17'(MAX_COLUMNS);
    cols  = (out_cols == '0) ? 17'd1 : {2'b0, out_cols};
    rows  = (out_rows == '0) ? 17'd1 : {1'b0, out_rows};
    cstep = (col_step == '0) ? 8'd1 : col_step;
    rstep = (row_step == '0) ? 8'd1 : row_step;
    done  = out_row_cnt >= rows;
    kept_row = in_row == next_row;
    keep  = !done && kept_row && in_col == next_col && {1'b0, out_col_cnt} < cols;
    row_end = in_col + 17'd1 >= rowlen;
    tag.fmt = fmt;
    tag.last_row = {1'b0, out_col_cnt} == cols - 17'd1;
    tag.last_frame = tag.last_row && out_row_cnt == rows - 17'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= '0; in_cols <= 15'd1; col_ofs <= '0; col_step <= 8'd1;
      out_cols <= 15'd1; row_ofs <= '0; row_step <= 8'd1; out_rows <= 16'd1;
      in_col <= '0; in_row <= '0; next_col <= '0; next_row <= '0;
      out_col_cnt <= '0; out_row_cnt <= '0;
    end else if (cfg_valid) begin
      // Write the register, then restart the frame with the new values.
      case (cfg_index)
        REG_FORMAT:   fmt <= cfg_data[1:0];
        REG_IN_COLS:  in_cols <= cfg_data[14:0];
        REG_COL_OFS:  col_ofs <= cfg_data[13:0];
        REG_COL_STEP: col_step <= cfg_data[7:0];
        REG_OUT_COLS: out_cols <= cfg_data[14:0];
        REG_ROW_OFS:  row_ofs <= cfg_data;
        REG_ROW_STEP: row_step <= cfg_data[7:0];
        REG_OUT_ROWS: out_rows <= cfg_data;
        default: ;
      endcase
      in_col <= '0; in_row <= '0;
      next_col <= (cfg_index == REG_COL_OFS) ? {3'b0, cfg_data[13:0]} : {3'b0, col_ofs};
      next_row <= (cfg_index == REG_ROW_OFS) ? {9'b0, cfg_data} : {9'b0, row_ofs};
      out_col_cnt <= '0; out_row_cnt <= '0;
    end else if (in_fire && !done) begin
      if (row_end) begin
        in_col <= '0;
        if (kept_row) begin
          out_row_cnt <= out_row_cnt + 17'd1;
          next_row <= next_row + {17'b0, rstep};
        end
        in_row <= in_row + 25'd1;
        next_col <= {3'b0, col_ofs};
        out_col_cnt <= '0;
      end else begin
        in_col <= in_col + 17'd1;
        if (keep) begin
          out_col_cnt <= out_col_cnt + 16'd1;
          next_col <= next_col + {9'b0, cstep};
        end
      end
    end
  end

endmodule

/* design/mdc_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdc_cordic
// Pipelined fixed-length CORDIC rotation, amplitude and phase to re and im.
// ----------------------------------------------------------------------------
module mdc_cordic import mdc_pkg::*; #(
  parameter int AMPLITUDE_BITS = 16,
  parameter int PHASE_BITS = 16,
  parameter int ROTATION_STAGES = 16
) (
  input  logic                             clk,
  input  logic                             adv,
  input  logic [AMPLITUDE_BITS-1:0]        amp,
  input  logic signed [PHASE_BITS-1:0]     phase,
  output logic signed [AMPLITUDE_BITS:0]   re,
  output logic signed [AMPLITUDE_BITS:0]   im
);

  localparam int XB = AMPLITUDE_BITS + GUARD_BITS + 4;
  localparam int NS = (ROTATION_STAGES < 24) ? ROTATION_STAGES : 24;

  logic signed [XB-1:0] xs [NS+1];
  logic signed [XB-1:0] ys [NS+1];
  logic signed [ANGLE_BITS-1:0] zs [NS+1];
  logic [AMPLITUDE_BITS+31:0] prod;
  logic signed [ANGLE_BITS-1:0] z0;
  logic signed [XB-1:0] x0;

  always_comb begin
    prod = {32'b0, amp} * {{AMPLITUDE_BITS{1'b0}}, INV_GAIN_Q32};
    x0 = XB'($signed({1'b0, prod[AMPLITUDE_BITS+31:32-GUARD_BITS]}));
    z0 = ANGLE_BITS'(phase) <<< (32 - PHASE_BITS);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (z0 > 34'sd1073741824) begin
        zs[0] <= z0 - 34'sd2147483648; xs[0] <= -x0;
      end else if (z0 < -34'sd1073741824) begin
        zs[0] <= z0 + 34'sd2147483648; xs[0] <= -x0;
      end else begin
        zs[0] <= z0; xs[0] <= x0;
      end
      ys[0] <= '0;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv) begin
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_entry(i);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_entry(i);
        end
      end
    end
  end

  function automatic logic signed [AMPLITUDE_BITS:0] round_sat(
      input logic signed [XB-1:0] v);
    logic signed [XB-1:0] r;
    logic signed [XB-1:0] lim;
    r = (v + XB'(1 << (GUARD_BITS - 1))) >>> GUARD_BITS;
    lim = XB'((1 << AMPLITUDE_BITS) - 1);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[AMPLITUDE_BITS:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      re <= round_sat(xs[NS]);
      im <= round_sat(ys[NS]);
    end
  end

endmodule

/* design/mdc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdc_back
// Pipelined back end: two rotations, products, format select, output stage.
// ----------------------------------------------------------------------------
module mdc_back import mdc_pkg::*; #(
  parameter int AMPLITUDE_BITS = 16,
  parameter int PHASE_BITS = 16,
  parameter int ROTATION_STAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  logic [AMPLITUDE_BITS-1:0]     amp_a,
  input  logic [PHASE_BITS-1:0]         ph_a,
  input  logic [AMPLITUDE_BITS-1:0]     amp_b,
  input  logic [PHASE_BITS-1:0]         ph_b,
  input  tag_t                          q_tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [4*WORD_BITS-1:0]        out_words,
  output tag_t                          out_tag
);

  localparam int NS = (ROTATION_STAGES < 24) ? ROTATION_STAGES : 24;
  localparam int LAT = NS + 2;          // CORDIC pipe incl. entry and rounding
  localparam int DEPTH = LAT + 2;       // plus product and sum stages
  localparam int PB = 2 * AMPLITUDE_BITS + 2;

  logic [DEPTH-1:0] vld;
  tag_t tg [DEPTH];
  logic adv;
  logic signed [AMPLITUDE_BITS:0] ra, ia, rb, ib;
  logic signed [PB-1:0] p_aa, p_ii, p_bb, p_jj, p_ab, p_ij, p_ib, p_ai;
  logic signed [AMPLITUDE_BITS:0] ra2, ia2, rb2, ib2;
  logic signed [WORD_BITS-1:0] w0, w1, w2, w3;

  // Stall the whole pipe while the last stage holds a result not taken.
  assign adv = !(vld[DEPTH-1] && !out_ready);
  assign q_ready = adv;

  mdc_cordic #(.AMPLITUDE_BITS(AMPLITUDE_BITS), .PHASE_BITS(PHASE_BITS),
               .ROTATION_STAGES(ROTATION_STAGES)) u_cor_a (
    .clk(clk), .adv(adv), .amp(amp_a), .phase(ph_a), .re(ra), .im(ia));
  mdc_cordic #(.AMPLITUDE_BITS(AMPLITUDE_BITS), .PHASE_BITS(PHASE_BITS),
               .ROTATION_STAGES(ROTATION_STAGES)) u_cor_b (
    .clk(clk), .adv(adv), .amp(amp_b), .phase(ph_b), .re(rb), .im(ib));

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[DEPTH-2:0], q_valid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tg[0] <= q_tag;
      for (int k = 1; k < DEPTH; k++) tg[k] <= tg[k-1];
      p_aa <= PB'(ra) * PB'(ra); p_ii <= PB'(ia) * PB'(ia);
      p_bb <= PB'(rb) * PB'(rb); p_jj <= PB'(ib) * PB'(ib);
      p_ab <= PB'(ra) * PB'(rb); p_ij <= PB'(ia) * PB'(ib);
      p_ib <= PB'(ia) * PB'(rb); p_ai <= PB'(ra) * PB'(ib);
      ra2 <= ra; ia2 <= ia; rb2 <= rb; ib2 <= ib;
      case (tg[LAT].fmt)
        FMT_COMPLEX: begin
          w0 <= WORD_BITS'(ra2); w1 <= WORD_BITS'(ia2);
          w2 <= WORD_BITS'(rb2); w3 <= WORD_BITS'(ib2);
        end
        FMT_POWER: begin
          w0 <= WORD_BITS'(p_aa + p_ii); w1 <= WORD_BITS'(p_bb + p_jj);
          w2 <= '0; w3 <= '0;
        end
        default: begin
          w0 <= WORD_BITS'(p_aa + p_ii); w1 <= WORD_BITS'(p_ab + p_ij);
          w2 <= WORD_BITS'(p_ib - p_ai); w3 <= WORD_BITS'(p_bb + p_jj);
        end
      endcase
    end
  end

  assign out_valid = vld[DEPTH-1];
  assign out_words = {w3, w2, w1, w0};
  assign out_tag = tg[DEPTH-1];

endmodule

/* design/modpha_to_dualpol_covariance.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modpha_to_dualpol_covariance
// Dual-channel polar to rectangular converter with crop, subsampling and
// C2 covariance output.
// ----------------------------------------------------------------------------
// Path: an accepted kept pixel passes the input queue, the CORDIC entry,
// the rotation stages, rounding, products and sums on the way to its result.
// Throughput: one pixel per cycle; the CORDIC pipe is fully pipelined and
// stalls as a whole only while the output holds a result not taken.
// Reset: synchronous rst restores register defaults and restarts the frame;
// any configuration write also restarts the frame.
module modpha_to_dualpol_covariance import mdc_pkg::*; #(
  parameter int MAX_COLUMNS = 16384,
  parameter int AMPLITUDE_BITS = 16,
  parameter int PHASE_BITS = 16,
  parameter int ROTATION_STAGES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // amplitude_a, phase_a, amplitude_b, phase_b (lowest first)
  input  logic [((2*(AMPLITUDE_BITS+PHASE_BITS)+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // word_a, word_b, word_c, word_d (lowest first)
  output logic [4*WORD_BITS-1:0] m_axis_tdata,
  output logic m_axis_tlast,            // last_in_row
  output logic m_axis_tuser,            // last_in_frame
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int AB = AMPLITUDE_BITS;
  localparam int PH = PHASE_BITS;
  localparam int PX = 2 * (AB + PH);

  logic keep, q_ready, q_valid, in_fire;
  tag_t f_tag, q_tag, o_tag;
  logic [PX-1:0] q_data;
  logic [4*WORD_BITS-1:0] words;

  assign cfg_ready = 1'b1;
  // Dropped pixels retire at once; kept ones enter the one-entry queue.
  assign s_axis_tready = !q_valid || q_ready;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  mdc_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_fire(in_fire), .keep(keep), .tag(f_tag));

  // Hold one classified pixel between front and back.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (s_axis_tready) begin
      q_valid <= in_fire && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      q_data <= s_axis_tdata[PX-1:0];
      q_tag <= f_tag;
    end
  end

  mdc_back #(.AMPLITUDE_BITS(AB), .PHASE_BITS(PH),
             .ROTATION_STAGES(ROTATION_STAGES)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready),
    .amp_a(q_data[AB-1:0]), .ph_a(q_data[AB+PH-1:AB]),
    .amp_b(q_data[2*AB+PH-1:AB+PH]), .ph_b(q_data[PX-1:2*AB+PH]),
    .q_tag(q_tag), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_words(words), .out_tag(o_tag));

  assign m_axis_tdata = words;
  assign m_axis_tlast = o_tag.last_row;
  assign m_axis_tuser = o_tag.last_frame;

endmodule

/* design/mdc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdc_checker
// Port-level checks for the converter.
// ----------------------------------------------------------------------------
module mdc_checker (
  input logic clk,
  input logic rst,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tlast,
  input logic m_axis_tuser,
  input logic cfg_ready
);

  a_frame_has_row: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast) else $error("frame end without row end");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_ready) else $error("config not ready");
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid) else $error("valid after reset");

endmodule

bind modpha_to_dualpol_covariance mdc_checker u_chk (
  .clk(clk), .rst(rst), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tlast(m_axis_tlast),
  .m_axis_tuser(m_axis_tuser), .cfg_ready(cfg_ready));
